>>> design/mpft_pkg.sv
package mpft_pkg;

   // Screen geometry and store layout.
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 32;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W        = $clog2(STORE_BYTES);

   // Field widths fixed by the interface.
   localparam int FONT_W_BITS = 5;
   localparam int FONT_H_BITS = 6;
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 2;

   // Printable character range accepted by a glyph row.
   localparam logic [7:0] CHAR_FIRST = 8'd32;
   localparam logic [7:0] CHAR_LAST  = 8'd126;

   // Configuration reset values.
   localparam logic [FONT_W_BITS-1:0] FONT_W_RESET = 5'd7;
   localparam logic [FONT_H_BITS-1:0] FONT_H_RESET = 6'd10;

   typedef enum logic [2:0] {
      ACT_FILL   = 3'd0,
      ACT_PIXEL  = 3'd1,
      ACT_CURSOR = 3'd2,
      ACT_GLYPH  = 3'd3,
      ACT_READ   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_OFFSCREEN = 2'd1,
      STAT_REJECT    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FONT_WIDTH  = 2'd0,
      CSR_FONT_HEIGHT = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PIXEL,
      ST_GLYPH,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   typedef struct packed {
      status_type status;
      logic [7:0] char_echo;
      logic [7:0] read_data;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } result_type;

endpackage

>>> design/mono_page_framebuffer_text_top.sv
// After a request is accepted, set cursor, unused actions, off-screen pixels, rejected glyph
// rows and a zero font width go straight to the result; an on-screen pixel does one frame
// store read-modify-write, a byte read does one frame store read, a drawn glyph row does one
// frame store read-modify-write per column, and fill writes every byte of the store.
// The controller returns to idle, raising req_ready, in the cycle that rsp_valid rises, unless
// the output register is still full. Reset is synchronous; after it the store is cleared to
// black, during which req_ready stays low; CSR writes are taken meanwhile.
module mono_page_framebuffer_text_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mpft_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpft_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_action,
   input  logic [7:0]                       req_x,
   input  logic [7:0]                       req_y,
   input  logic                             req_color,
   input  logic [7:0]                       req_char_code,
   input  logic [4:0]                       req_glyph_row,
   input  logic [15:0]                      req_row_bits,
   input  logic [8:0]                       req_byte_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [7:0]                       rsp_char_echo,
   output logic [7:0]                       rsp_read_data,
   output logic [7:0]                       rsp_cursor_col,
   output logic [7:0]                       rsp_cursor_row
);
   import mpft_pkg::*;

   // The controller owns the cursor, the font registers and the sequencing of every
   // action. The frame store is a single synchronous RAM with a registered read port.
   store_wr_type      store_wr;
   logic [ADDR_W-1:0] store_rd_addr;
   logic [7:0]        store_rd_data;
   logic              res_valid;
   result_type        result;

   // Output register: a finished result moves here so the controller can accept the
   // next request while this beat waits for rsp_ready.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   logic       slot_free;
   logic       load;

   mpft_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_x            (req_x),
      .req_y            (req_y),
      .req_color        (req_color),
      .req_char_code    (req_char_code),
      .req_glyph_row    (req_glyph_row),
      .req_row_bits     (req_row_bits),
      .req_byte_address (req_byte_address),
      .slot_free        (slot_free),
      .res_valid        (res_valid),
      .result           (result),
      .store_wr         (store_wr),
      .store_rd_addr    (store_rd_addr),
      .store_rd_data    (store_rd_data)
   );

   mpft_store u_store (
      .clock    (clock),
      .store_wr (store_wr),
      .rd_addr  (store_rd_addr),
      .rd_data  (store_rd_data)
   );

   // The slot is free when empty or when its beat leaves at this edge.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load      = res_valid && slot_free;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_char_echo  = rsp_ff.char_echo;
   assign rsp_read_data  = rsp_ff.read_data;
   assign rsp_cursor_col = rsp_ff.cursor_col;
   assign rsp_cursor_row = rsp_ff.cursor_row;

`ifndef NO_ASSERTIONS
   a_result_held_until_slot_free: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !slot_free) |=> res_valid)
      else $error("finished result dropped while the output register was full");
`endif

endmodule

>>> design/mpft_store.sv
module mpft_store (
   input  logic                        clock,
   input  mpft_pkg::store_wr_type      store_wr,
   input  logic [mpft_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                  rd_data
);
   import mpft_pkg::*;

   logic [7:0] store_ff [STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mpft_ctrl.sv
module mpft_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mpft_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mpft_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_action,
   input  logic [7:0]                       req_x,
   input  logic [7:0]                       req_y,
   input  logic                             req_color,
   input  logic [7:0]                       req_char_code,
   input  logic [4:0]                       req_glyph_row,
   input  logic [15:0]                      req_row_bits,
   input  logic [8:0]                       req_byte_address,
   input  logic                             slot_free,
   output logic                             res_valid,
   output mpft_pkg::result_type             result,
   output mpft_pkg::store_wr_type           store_wr,
   output logic [mpft_pkg::ADDR_W-1:0]      store_rd_addr,
   input  logic [7:0]                       store_rd_data
);
   import mpft_pkg::*;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [4:0]             col_ff, col_in;
   logic [15:0]            bits_ff, bits_in;
   logic [7:0]             mask_ff, mask_in;
   logic                   color_ff, color_in;
   logic [7:0]             fill_byte_ff, fill_byte_in;
   status_type             status_ff, status_in;
   logic [7:0]             echo_ff, echo_in;
   logic [7:0]             rdata_ff, rdata_in;
   logic [7:0]             cursor_x_ff, cursor_x_in;
   logic [7:0]             cursor_y_ff, cursor_y_in;
   logic [FONT_W_BITS-1:0] font_width_ff, font_width_in;
   logic [FONT_H_BITS-1:0] font_height_ff, font_height_in;

   logic [8:0]        col_end;
   logic [8:0]        row_end;
   logic [8:0]        glyph_y;
   logic              char_ok;
   logic              glyph_ok;
   logic              last_row;
   logic [ADDR_W-1:0] pixel_addr;
   logic [ADDR_W-1:0] glyph_addr;

   function automatic logic [7:0] paint(input logic [7:0] data, input logic [7:0] mask,
                                        input logic white);
      paint = white ? (data | mask) : (data & ~mask);
   endfunction

   // Glyph row admission checks and the byte addresses of the first pixel.
   assign col_end  = 9'(cursor_x_ff) + 9'(font_width_ff);
   assign row_end  = 9'(cursor_y_ff) + 9'(font_height_ff);
   assign glyph_y  = 9'(cursor_y_ff) + 9'(req_glyph_row);
   assign char_ok  = (req_char_code >= CHAR_FIRST) && (req_char_code <= CHAR_LAST);
   assign glyph_ok = char_ok && (32'(col_end) <= SCREEN_WIDTH) &&
                     (32'(row_end) <= SCREEN_HEIGHT) &&
                     (6'(req_glyph_row) < font_height_ff);
   assign last_row = (6'(req_glyph_row) == font_height_ff - 6'd1);

   assign pixel_addr = ADDR_W'(32'(req_x) + 32'(req_y[7:3]) * SCREEN_WIDTH);
   assign glyph_addr = ADDR_W'(32'(cursor_x_ff) + 32'(glyph_y[8:3]) * SCREEN_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         fill_byte_ff   <= '0;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         font_width_ff  <= FONT_W_RESET;
         font_height_ff <= FONT_H_RESET;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         fill_byte_ff   <= fill_byte_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         font_width_ff  <= font_width_in;
         font_height_ff <= font_height_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      col_ff    <= col_in;
      bits_ff   <= bits_in;
      mask_ff   <= mask_in;
      color_ff  <= color_in;
      status_ff <= status_in;
      echo_ff   <= echo_in;
      rdata_ff  <= rdata_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      addr_in        = addr_ff;
      col_in         = col_ff;
      bits_in        = bits_ff;
      mask_in        = mask_ff;
      color_in       = color_ff;
      fill_byte_in   = fill_byte_ff;
      status_in      = status_ff;
      echo_in        = echo_ff;
      rdata_in       = rdata_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      font_width_in  = font_width_ff;
      font_height_in = font_height_ff;
      store_wr       = '0;
      store_rd_addr  = addr_ff + ADDR_W'(1);

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FONT_WIDTH:  font_width_in  = csr_wdata[FONT_W_BITS-1:0];
            CSR_FONT_HEIGHT: font_height_in = csr_wdata[FONT_H_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR, ST_FILL: begin
            store_wr.en   = 1'b1;
            store_wr.addr = cnt_ff;
            store_wr.data = fill_byte_ff;
            cnt_in        = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = (state_ff == ST_CLEAR) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               status_in = STAT_DONE;
               echo_in   = '0;
               rdata_in  = '0;
               color_in  = req_color;
               state_in  = ST_DONE;
               case (action_type'(req_action))
                  ACT_FILL: begin
                     fill_byte_in = {8{req_color}};
                     cnt_in       = '0;
                     state_in     = ST_FILL;
                  end
                  ACT_PIXEL: begin
                     if ((32'(req_x) >= SCREEN_WIDTH) || (32'(req_y) >= SCREEN_HEIGHT)) begin
                        status_in = STAT_OFFSCREEN;
                     end else begin
                        store_rd_addr = pixel_addr;
                        addr_in       = pixel_addr;
                        mask_in       = 8'd1 << req_y[2:0];
                        state_in      = ST_PIXEL;
                     end
                  end
                  ACT_CURSOR: begin
                     cursor_x_in = req_x;
                     cursor_y_in = req_y;
                  end
                  ACT_GLYPH: begin
                     if (!glyph_ok) begin
                        status_in = STAT_REJECT;
                     end else begin
                        echo_in = req_char_code;
                        if (last_row) begin
                           cursor_x_in = col_end[7:0];
                        end
                        if (font_width_ff != '0) begin
                           store_rd_addr = glyph_addr;
                           addr_in       = glyph_addr;
                           mask_in       = 8'd1 << glyph_y[2:0];
                           bits_in       = req_row_bits;
                           col_in        = '0;
                           state_in      = ST_GLYPH;
                        end
                     end
                  end
                  ACT_READ: begin
                     if (32'(req_byte_address) < STORE_BYTES) begin
                        store_rd_addr = ADDR_W'(req_byte_address);
                        state_in      = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_PIXEL: begin
            store_wr.en   = 1'b1;
            store_wr.addr = addr_ff;
            store_wr.data = paint(store_rd_data, mask_ff, color_ff);
            state_in      = ST_DONE;
         end
         ST_GLYPH: begin
            // The byte of column col_ff arrives now; the next column's read goes out.
            store_wr.en   = 1'b1;
            store_wr.addr = addr_ff;
            store_wr.data = paint(store_rd_data, mask_ff, ~(bits_ff[15] ^ color_ff));
            addr_in       = addr_ff + ADDR_W'(1);
            bits_in       = {bits_ff[14:0], 1'b0};
            col_in        = col_ff + 5'd1;
            if (col_ff == font_width_ff - 5'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            rdata_in = store_rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign res_valid         = (state_ff == ST_DONE);
   assign result.status     = status_ff;
   assign result.char_echo  = echo_ff;
   assign result.read_data  = rdata_ff;
   assign result.cursor_col = cursor_x_ff;
   assign result.cursor_row = cursor_y_ff;

`ifndef NO_ASSERTIONS
   a_write_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (state_ff == ST_CLEAR || state_ff == ST_FILL ||
                       state_ff == ST_PIXEL || state_ff == ST_GLYPH))
      else $error("frame store written outside a drawing state");

   a_glyph_column_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GLYPH) |-> (col_ff < font_width_ff))
      else $error("glyph column ran past the font width");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start any work");
`endif

endmodule
